@@ rtl/core/rbs_pkg.sv @@
// ----------------------------------------------------------------------------
// rbs_pkg
// Shared types and constants for the ray/box slab test core.
// ----------------------------------------------------------------------------
package rbs_pkg;

    localparam int DATA_W = 32;       // port width of every coordinate
    localparam int T_W    = 32;       // signed Q16.16 slab distance
    localparam int FRAC   = 16;
    localparam int EXT_W  = 42;       // room for the unbounded near/far marks
    localparam int AXES   = 3;

    localparam logic signed [T_W-1:0]   T_MAX   = 32'sh7FFF_FFFF;
    localparam logic signed [T_W-1:0]   T_MIN   = 32'sh8000_0000;
    localparam logic signed [EXT_W-1:0] POS_INF = 42'sh100_0000_0000;
    localparam logic signed [EXT_W-1:0] NEG_INF = -42'sh100_0000_0000;

    // what one axis lane reports to the merge stage
    typedef struct packed {
        logic signed [T_W-1:0] tmin;
        logic signed [T_W-1:0] tmax;
        logic                  dz;      // direction component is zero
        logic                  in_slab; // origin within the slab
    } lane_res_t;

endpackage

@@ rtl/core/rbs_div.sv @@
// ----------------------------------------------------------------------------
// rbs_div
// Pipelined unsigned restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module rbs_div #(
    parameter int NB = 48,
    parameter int DB = 32
) (
    input  logic          clk,
    input  logic          en,
    input  logic [NB-1:0] num,
    input  logic [DB-1:0] den,
    output logic [NB-1:0] quo
);
    logic [DB-1:0] r_reg [NB+1];
    logic [NB-1:0] n_reg [NB+1];
    logic [NB-1:0] q_reg [NB+1];
    logic [DB-1:0] d_reg [NB+1];

    assign r_reg[0] = '0;
    assign n_reg[0] = num;
    assign q_reg[0] = '0;
    assign d_reg[0] = den;

    for (genvar i = 0; i < NB; i++) begin : g_stage
        logic [DB:0] rs;
        logic [DB:0] rd;
        logic        ge;
        assign rs = {r_reg[i], n_reg[i][NB-1]};
        assign ge = rs >= {1'b0, d_reg[i]};
        assign rd = ge ? rs - {1'b0, d_reg[i]} : rs;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r_reg[i+1] <= rd[DB-1:0];
                n_reg[i+1] <= {n_reg[i][NB-2:0], 1'b0};
                q_reg[i+1] <= {q_reg[i][NB-2:0], ge};
                d_reg[i+1] <= d_reg[i];
            end
        end
    end

    assign quo = q_reg[NB];
endmodule

@@ rtl/core/rbs_lane.sv @@
// ----------------------------------------------------------------------------
// rbs_lane
// One axis: slab distances to both bounds, saturated and ordered.
// ----------------------------------------------------------------------------
module rbs_lane #(
    parameter int COORD_BITS = 32
) (
    input  logic                          clk,
    input  logic                          en,
    input  logic [rbs_pkg::DATA_W-1:0]    origin,
    input  logic [rbs_pkg::DATA_W-1:0]    dir,
    input  logic [rbs_pkg::DATA_W-1:0]    lo,
    input  logic [rbs_pkg::DATA_W-1:0]    hi,
    output rbs_pkg::lane_res_t            res
);
    import rbs_pkg::*;

    localparam int W  = (COORD_BITS < 32) ? COORD_BITS : 32;
    localparam int NB = W + FRAC;

    typedef struct packed {
        logic neg_a;
        logic neg_b;
        logic dz;
        logic in_slab;
    } side_t;

    logic signed [W-1:0] o, d, l, h;
    logic signed [W:0]   diff_a, diff_b, abs_a, abs_b, abs_d;
    assign o = signed'(origin[W-1:0]);
    assign d = signed'(dir[W-1:0]);
    assign l = signed'(lo[W-1:0]);
    assign h = signed'(hi[W-1:0]);
    assign diff_a = (W+1)'(l) - (W+1)'(o);
    assign diff_b = (W+1)'(h) - (W+1)'(o);
    assign abs_a  = diff_a[W] ? -diff_a : diff_a;
    assign abs_b  = diff_b[W] ? -diff_b : diff_b;
    assign abs_d  = d[W-1] ? -(W+1)'(d) : (W+1)'(d);

    logic [NB-1:0] num_a_reg, num_b_reg;
    logic [W-1:0]  den_reg;
    side_t         side_reg [NB+1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_a_reg   <= {abs_a[W-1:0], {FRAC{1'b0}}};
            num_b_reg   <= {abs_b[W-1:0], {FRAC{1'b0}}};
            den_reg     <= abs_d[W-1:0];
            side_reg[0] <= '{neg_a:   diff_a[W] ^ d[W-1],
                             neg_b:   diff_b[W] ^ d[W-1],
                             dz:      d == '0,
                             in_slab: (l <= o) && (o <= h)};
        end
    end

    for (genvar i = 0; i < NB; i++) begin : g_side
        always_ff @(posedge clk)
        begin
            if (en)
                side_reg[i+1] <= side_reg[i];
        end
    end

    logic [NB-1:0] q_a, q_b;

    rbs_div #(.NB(NB), .DB(W)) u_div_a (
        .clk(clk), .en(en), .num(num_a_reg), .den(den_reg), .quo(q_a)
    );
    rbs_div #(.NB(NB), .DB(W)) u_div_b (
        .clk(clk), .en(en), .num(num_b_reg), .den(den_reg), .quo(q_b)
    );

    function automatic logic signed [T_W-1:0] sat_q(input logic [NB-1:0] q,
                                                    input logic neg);
        logic [63:0] q64;
        q64 = 64'(q);
        if (neg)
            sat_q = (q64 > 64'd2147483648) ? T_MIN : T_W'(-q64);
        else
            sat_q = (q64 > 64'd2147483647) ? T_MAX : T_W'(q64);
    endfunction

    logic signed [T_W-1:0] t_a, t_b;
    assign t_a = sat_q(q_a, side_reg[NB].neg_a);
    assign t_b = sat_q(q_b, side_reg[NB].neg_b);

    lane_res_t res_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg.tmin    <= (t_a < t_b) ? t_a : t_b;
            res_reg.tmax    <= (t_a < t_b) ? t_b : t_a;
            res_reg.dz      <= side_reg[NB].dz;
            res_reg.in_slab <= side_reg[NB].in_slab;
        end
    end
    assign res = res_reg;
endmodule

@@ rtl/core/rbs_merge.sv @@
// ----------------------------------------------------------------------------
// rbs_merge
// Combines the three axis lanes into hit flag and distance (entry if positive, else exit).
// ----------------------------------------------------------------------------
module rbs_merge (
    input  logic                 clk,
    input  logic                 en,
    input  rbs_pkg::lane_res_t   lanes [rbs_pkg::AXES],
    output logic                 hit,
    output logic [30:0]          hit_distance
);
    import rbs_pkg::*;

    logic signed [EXT_W-1:0] near_t, far_t, dist_sel;
    logic                    ok, hit_next;
    logic [30:0]             dist_next;

    always_comb
    begin
        near_t = NEG_INF;
        far_t  = POS_INF;
        ok     = 1'b1;
        for (int a = 0; a < AXES; a++)
        begin
            if (lanes[a].dz)
            begin
                if (!lanes[a].in_slab)
                    ok = 1'b0;
            end
            else
            begin
                if (EXT_W'(lanes[a].tmin) > near_t)
                    near_t = EXT_W'(lanes[a].tmin);
                if (EXT_W'(lanes[a].tmax) < far_t)
                    far_t = EXT_W'(lanes[a].tmax);
            end
        end
        hit_next = ok && (near_t <= far_t) && (far_t >= 0);
        dist_sel = (near_t > 0) ? near_t : far_t;
        if (!hit_next || dist_sel < 0)
            dist_next = '0;
        else if (dist_sel > EXT_W'(T_MAX))
            dist_next = 31'h7FFF_FFFF;
        else
            dist_next = dist_sel[30:0];
    end

    logic        hit_reg;
    logic [30:0] dist_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hit_reg  <= hit_next;
            dist_reg <= dist_next;
        end
    end
    assign hit          = hit_reg;
    assign hit_distance = dist_reg;
endmodule

@@ rtl/core/ray_box_slab_test_core.sv @@
// Path: lane input register, divider stages, lane result register, merge register.
// One item per cycle unless stalled; each divider retires one quotient bit per stage.
// The whole pipeline holds while a finished result waits on out_ready.
// Reset clears only the stage valid bits; no clearing pass.
// ----------------------------------------------------------------------------
// ray_box_slab_test_core
// Ray versus axis-aligned box slab test, three parallel axis lanes and merge.
// ----------------------------------------------------------------------------
module ray_box_slab_test_core #(
    parameter int COORD_BITS = 32
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [rbs_pkg::DATA_W-1:0] origin_x,
    input  logic [rbs_pkg::DATA_W-1:0] origin_y,
    input  logic [rbs_pkg::DATA_W-1:0] origin_z,
    input  logic [rbs_pkg::DATA_W-1:0] dir_x,
    input  logic [rbs_pkg::DATA_W-1:0] dir_y,
    input  logic [rbs_pkg::DATA_W-1:0] dir_z,
    input  logic [rbs_pkg::DATA_W-1:0] lo_x,
    input  logic [rbs_pkg::DATA_W-1:0] lo_y,
    input  logic [rbs_pkg::DATA_W-1:0] lo_z,
    input  logic [rbs_pkg::DATA_W-1:0] hi_x,
    input  logic [rbs_pkg::DATA_W-1:0] hi_y,
    input  logic [rbs_pkg::DATA_W-1:0] hi_z,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic                       hit,
    output logic [30:0]                hit_distance
);
    import rbs_pkg::*;

    localparam int W   = (COORD_BITS < 32) ? COORD_BITS : 32;
    localparam int LAT = W + FRAC + 3;

    logic           adv;
    logic [LAT-1:0] vld_reg, vld_next;

    assign adv      = !vld_reg[LAT-1] || out_ready;
    assign in_ready = adv;
    assign vld_next = {vld_reg[LAT-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= vld_next;
    end

    logic [DATA_W-1:0] org [AXES];
    logic [DATA_W-1:0] dr  [AXES];
    logic [DATA_W-1:0] bl  [AXES];
    logic [DATA_W-1:0] bh  [AXES];
    lane_res_t         lanes [AXES];

    assign org = '{origin_x, origin_y, origin_z};
    assign dr  = '{dir_x, dir_y, dir_z};
    assign bl  = '{lo_x, lo_y, lo_z};
    assign bh  = '{hi_x, hi_y, hi_z};

    for (genvar a = 0; a < AXES; a++) begin : g_lane
        rbs_lane #(.COORD_BITS(COORD_BITS)) u_lane (
            .clk(clk), .en(adv),
            .origin(org[a]), .dir(dr[a]), .lo(bl[a]), .hi(bh[a]),
            .res(lanes[a])
        );
    end

    rbs_merge u_merge (
        .clk(clk), .en(adv), .lanes(lanes),
        .hit(hit), .hit_distance(hit_distance)
    );

    assign out_valid = vld_reg[LAT-1];
endmodule
